// File: rtl/rlm_pkg.sv
package rlm_pkg;

   localparam int DEF_THREAD_COUNT = 16;
   localparam int DEF_MAX_HOLD     = 255;

   localparam int ID_W     = 4;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 3;
   localparam int HOLD_W   = 8;
   localparam int FLAG_W   = 1 << ID_W;

   localparam logic [CMD_W-1:0] CMD_LOCK       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TRY_LOCK   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UNLOCK     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_WAIT       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_NOTIFY     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_NOTIFY_ALL = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BUSY       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_OWNER  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SATURATED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_ALREADY_Q  = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic move;
      logic grant;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic notify_any;
      logic notify_all;
      logic can_move;
   } dp_status_type;

endpackage

// File: rtl/rlm_ctrl.sv
module rlm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rlm_pkg::dp_status_type dp_status,
   output rlm_pkg::ctl_cmd_type   ctl_cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_EXEC   = 6'b000010,
      S_MOVE   = 6'b000100,
      S_SETTLE = 6'b001000,
      S_GRANT  = 6'b010000,
      S_OUT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl_cmd  = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl_cmd.capture = 1'b1;
               state_in        = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl_cmd.exec = 1'b1;
            state_in     = dp_status.notify_any ? S_MOVE : S_OUT;
         end
         S_MOVE: begin
            if (dp_status.can_move) begin
               ctl_cmd.move = 1'b1;
               state_in     = S_SETTLE;
            end else begin
               state_in = S_GRANT;
            end
         end
         // let the queue read registers catch up with the new heads
         S_SETTLE: begin
            state_in = dp_status.notify_all ? S_MOVE : S_GRANT;
         end
         S_GRANT: begin
            ctl_cmd.grant = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

endmodule

// File: rtl/rlm_dp.sv
module rlm_dp #(
   parameter int THREAD_COUNT = rlm_pkg::DEF_THREAD_COUNT,
   parameter int MAX_HOLD     = rlm_pkg::DEF_MAX_HOLD
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [rlm_pkg::CMD_W-1:0]       req_cmd,
   input  logic [rlm_pkg::ID_W-1:0]        req_requester_id,
   input  rlm_pkg::ctl_cmd_type            ctl_cmd,
   output rlm_pkg::dp_status_type          dp_status,
   output logic [rlm_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_acquired,
   output logic                            rsp_handoff_valid,
   output logic [rlm_pkg::ID_W-1:0]        rsp_handoff_thread,
   output logic                            rsp_owner_valid,
   output logic [rlm_pkg::ID_W-1:0]        rsp_owner_thread,
   output logic [rlm_pkg::HOLD_W-1:0]      rsp_hold_count
);

   localparam int DEPTH = THREAD_COUNT;
   localparam int PW    = $clog2(DEPTH);
   localparam int FW    = $clog2(DEPTH + 1);
   localparam int CW    = (MAX_HOLD > 1) ? $clog2(MAX_HOLD + 1) : 1;
   localparam int IW    = rlm_pkg::ID_W;
   localparam int EW    = IW + CW;

   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);
   localparam logic [CW-1:0] HOLD_MAX = CW'(MAX_HOLD);
   localparam logic [CW-1:0] ONE      = CW'(1);

   // request latch
   logic [rlm_pkg::CMD_W-1:0] cmd_ff;
   logic [IW-1:0]             req_id_ff;

   // owner and result
   logic                         owner_present_ff, owner_present_in;
   logic [IW-1:0]                owner_id_ff, owner_id_in;
   logic [CW-1:0]                owner_count_ff, owner_count_in;
   logic [rlm_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         handoff_ff, handoff_in;
   logic [IW-1:0]                hthread_ff, hthread_in;
   logic                         moved_ff, moved_in;
   logic [rlm_pkg::FLAG_W-1:0]   flags_ff, flags_in;

   // queues
   logic [EW-1:0] ready_mem [DEPTH];
   logic [EW-1:0] wait_mem  [DEPTH];
   logic [EW-1:0] ready_rd_ff, wait_rd_ff;
   logic [PW-1:0] ready_head_ff, ready_head_in, ready_tail_ff, ready_tail_in;
   logic [PW-1:0] wait_head_ff, wait_head_in, wait_tail_ff, wait_tail_in;
   logic [FW-1:0] ready_fill_ff, ready_fill_in, wait_fill_ff, wait_fill_in;
   logic          ready_we, wait_we;
   logic [EW-1:0] ready_wdata, wait_wdata;

   logic is_owner, queued, grant_req;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   assign is_owner = owner_present_ff && (owner_id_ff == req_id_ff);
   assign queued   = flags_ff[req_id_ff];

   always_comb begin
      owner_present_in = owner_present_ff;
      owner_id_in      = owner_id_ff;
      owner_count_in   = owner_count_ff;
      status_in        = status_ff;
      handoff_in       = handoff_ff;
      hthread_in       = hthread_ff;
      moved_in         = moved_ff;
      flags_in         = flags_ff;
      ready_head_in    = ready_head_ff;
      ready_tail_in    = ready_tail_ff;
      ready_fill_in    = ready_fill_ff;
      wait_head_in     = wait_head_ff;
      wait_tail_in     = wait_tail_ff;
      wait_fill_in     = wait_fill_ff;
      ready_we         = 1'b0;
      wait_we          = 1'b0;
      ready_wdata      = {req_id_ff, ONE};
      wait_wdata       = {req_id_ff, owner_count_ff};
      grant_req        = 1'b0;

      if (ctl_cmd.capture) begin
         moved_in = 1'b0;
      end

      if (ctl_cmd.exec) begin
         status_in  = rlm_pkg::ST_OK;
         handoff_in = 1'b0;
         hthread_in = '0;
         case (cmd_ff)
            rlm_pkg::CMD_LOCK, rlm_pkg::CMD_TRY_LOCK: begin
               if (queued) begin
                  status_in = rlm_pkg::ST_ALREADY_Q;
               end else if (!owner_present_ff) begin
                  owner_present_in = 1'b1;
                  owner_id_in      = req_id_ff;
                  owner_count_in   = ONE;
               end else if (is_owner) begin
                  if (owner_count_ff >= HOLD_MAX) begin
                     status_in = rlm_pkg::ST_SATURATED;
                  end else begin
                     owner_count_in = owner_count_ff + 1'b1;
                  end
               end else if (cmd_ff == rlm_pkg::CMD_TRY_LOCK) begin
                  status_in = rlm_pkg::ST_BUSY;
               end else if (ready_fill_ff < FILL_MAX) begin
                  ready_we            = 1'b1;
                  ready_tail_in       = ptr_next(ready_tail_ff);
                  ready_fill_in       = ready_fill_ff + 1'b1;
                  flags_in[req_id_ff] = 1'b1;
                  status_in           = rlm_pkg::ST_QUEUED;
               end else begin
                  status_in = rlm_pkg::ST_BUSY;
               end
            end
            rlm_pkg::CMD_UNLOCK: begin
               if (!is_owner) begin
                  status_in = rlm_pkg::ST_NOT_OWNER;
               end else begin
                  owner_count_in = owner_count_ff - 1'b1;
                  if (owner_count_ff == ONE) begin
                     owner_present_in = 1'b0;
                     owner_id_in      = '0;
                     grant_req        = 1'b1;
                  end
               end
            end
            rlm_pkg::CMD_WAIT: begin
               if (!is_owner) begin
                  status_in = rlm_pkg::ST_NOT_OWNER;
               end else if (wait_fill_ff < FILL_MAX) begin
                  wait_we             = 1'b1;
                  wait_tail_in        = ptr_next(wait_tail_ff);
                  wait_fill_in        = wait_fill_ff + 1'b1;
                  flags_in[req_id_ff] = 1'b1;
                  owner_present_in    = 1'b0;
                  owner_id_in         = '0;
                  owner_count_in      = '0;
                  grant_req           = 1'b1;
                  status_in           = rlm_pkg::ST_QUEUED;
               end else begin
                  status_in = rlm_pkg::ST_BUSY;
               end
            end
            default: begin
            end
         endcase
      end

      // move the wait head to the ready tail
      if (ctl_cmd.move) begin
         wait_head_in  = ptr_next(wait_head_ff);
         wait_fill_in  = wait_fill_ff - 1'b1;
         ready_we      = 1'b1;
         ready_wdata   = wait_rd_ff;
         ready_tail_in = ptr_next(ready_tail_ff);
         ready_fill_in = ready_fill_ff + 1'b1;
         moved_in      = 1'b1;
      end

      if (ctl_cmd.grant && !owner_present_ff &&
          (moved_ff || cmd_ff == rlm_pkg::CMD_NOTIFY_ALL)) begin
         grant_req = 1'b1;
      end

      // hand the lock to the ready head with its saved count
      if (grant_req && ready_fill_ff != '0) begin
         owner_present_in                 = 1'b1;
         owner_id_in                      = ready_rd_ff[EW-1 -: IW];
         owner_count_in                   = ready_rd_ff[CW-1:0];
         flags_in[ready_rd_ff[EW-1 -: IW]] = 1'b0;
         ready_head_in                    = ptr_next(ready_head_ff);
         ready_fill_in                    = ready_fill_ff - 1'b1;
         handoff_in                       = 1'b1;
         hthread_in                       = ready_rd_ff[EW-1 -: IW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_present_ff <= 1'b0;
         owner_id_ff      <= '0;
         owner_count_ff   <= '0;
         flags_ff         <= '0;
         ready_head_ff    <= '0;
         ready_tail_ff    <= '0;
         ready_fill_ff    <= '0;
         wait_head_ff     <= '0;
         wait_tail_ff     <= '0;
         wait_fill_ff     <= '0;
         moved_ff         <= 1'b0;
      end else begin
         owner_present_ff <= owner_present_in;
         owner_id_ff      <= owner_id_in;
         owner_count_ff   <= owner_count_in;
         flags_ff         <= flags_in;
         ready_head_ff    <= ready_head_in;
         ready_tail_ff    <= ready_tail_in;
         ready_fill_ff    <= ready_fill_in;
         wait_head_ff     <= wait_head_in;
         wait_tail_ff     <= wait_tail_in;
         wait_fill_ff     <= wait_fill_in;
         moved_ff         <= moved_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.capture) begin
         cmd_ff    <= req_cmd;
         req_id_ff <= req_requester_id;
      end
      status_ff  <= status_in;
      handoff_ff <= handoff_in;
      hthread_ff <= hthread_in;
   end

   always_ff @(posedge clock) begin
      if (ready_we) begin
         ready_mem[ready_tail_ff] <= ready_wdata;
      end
      ready_rd_ff <= ready_mem[ready_head_ff];
   end

   always_ff @(posedge clock) begin
      if (wait_we) begin
         wait_mem[wait_tail_ff] <= wait_wdata;
      end
      wait_rd_ff <= wait_mem[wait_head_ff];
   end

   assign dp_status.notify_any = (cmd_ff == rlm_pkg::CMD_NOTIFY) ||
                                 (cmd_ff == rlm_pkg::CMD_NOTIFY_ALL);
   assign dp_status.notify_all = (cmd_ff == rlm_pkg::CMD_NOTIFY_ALL);
   assign dp_status.can_move   = (wait_fill_ff != '0) && (ready_fill_ff < FILL_MAX);

   assign rsp_status         = status_ff;
   assign rsp_acquired       = is_owner;
   assign rsp_handoff_valid  = handoff_ff;
   assign rsp_handoff_thread = handoff_ff ? hthread_ff : '0;
   assign rsp_owner_valid    = owner_present_ff;
   assign rsp_owner_thread   = owner_present_ff ? owner_id_ff : '0;
   assign rsp_hold_count     = owner_present_ff ? rlm_pkg::HOLD_W'(owner_count_ff) : '0;

endmodule

// File: rtl/recursive_lock_monitor.sv
// Recursive lock monitor: one lock with a nesting count, a FIFO ready queue
// and a FIFO condition wait queue, each THREAD_COUNT entries deep. Each item
// carries a command (lock, try_lock, unlock, wait, notify, notify_all) and a
// thread id, and returns exactly one result item with a status code, the
// owner after the command and any handoff from the ready queue. The block
// takes one item at a time: lock, try_lock, unlock and wait pass from the
// execute state straight to the output state; notify and notify_all go
// through the move state and the grant state, with a settle state after
// each move, since every move pops the wait queue memory whose head read
// is registered; notify_all moves waiters until no more can be moved.
// The result is held in the output register while rsp_stall is high; a new
// item is taken once the result has gone. Hold counts wider than 8 bits show
// their low byte on rsp_hold_count.
module recursive_lock_monitor #(
   parameter int THREAD_COUNT = rlm_pkg::DEF_THREAD_COUNT,
   parameter int MAX_HOLD     = rlm_pkg::DEF_MAX_HOLD
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rlm_pkg::CMD_W-1:0]    req_cmd,
   input  logic [rlm_pkg::ID_W-1:0]     req_requester_id,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rlm_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_acquired,
   output logic                         rsp_handoff_valid,
   output logic [rlm_pkg::ID_W-1:0]     rsp_handoff_thread,
   output logic                         rsp_owner_valid,
   output logic [rlm_pkg::ID_W-1:0]     rsp_owner_thread,
   output logic [rlm_pkg::HOLD_W-1:0]   rsp_hold_count
);

   rlm_pkg::ctl_cmd_type   ctl_cmd;
   rlm_pkg::dp_status_type dp_status;

   // sequence the item: capture, execute, move waiters, grant, present
   rlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .ctl_cmd   (ctl_cmd)
   );

   // owner state, queues and result registers
   rlm_dp #(
      .THREAD_COUNT (THREAD_COUNT),
      .MAX_HOLD     (MAX_HOLD)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_requester_id   (req_requester_id),
      .ctl_cmd            (ctl_cmd),
      .dp_status          (dp_status),
      .rsp_status         (rsp_status),
      .rsp_acquired       (rsp_acquired),
      .rsp_handoff_valid  (rsp_handoff_valid),
      .rsp_handoff_thread (rsp_handoff_thread),
      .rsp_owner_valid    (rsp_owner_valid),
      .rsp_owner_thread   (rsp_owner_thread),
      .rsp_hold_count     (rsp_hold_count)
   );

endmodule

// File: tb/tb_lock_checker.sv
`timescale 1ns / 100ps

module tb_lock_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [rlm_pkg::CMD_W-1:0]    req_cmd,
   input  logic [rlm_pkg::ID_W-1:0]     req_requester_id,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [rlm_pkg::STATUS_W-1:0] rsp_status,
   input  logic                         rsp_acquired,
   input  logic                         rsp_handoff_valid,
   input  logic [rlm_pkg::ID_W-1:0]     rsp_handoff_thread,
   input  logic                         rsp_owner_valid,
   input  logic [rlm_pkg::ID_W-1:0]     rsp_owner_thread,
   input  logic [rlm_pkg::HOLD_W-1:0]   rsp_hold_count,
   output int                           fail_count,
   output int                           pending_count
);

   localparam int NTH = rlm_pkg::DEF_THREAD_COUNT;

   typedef struct packed {
      logic [rlm_pkg::STATUS_W-1:0] status;
      logic                         acquired;
      logic                         handoff_valid;
      logic [rlm_pkg::ID_W-1:0]     handoff_thread;
      logic                         owner_valid;
      logic [rlm_pkg::ID_W-1:0]     owner_thread;
      logic [rlm_pkg::HOLD_W-1:0]   hold_count;
   } lock_result_type;

   typedef struct {
      logic [rlm_pkg::ID_W-1:0] id;
      int                       count;
   } slot_type;

   lock_result_type          result_q[$];
   slot_type                 ready_fifo[$];
   slot_type                 wait_fifo[$];
   logic                     held;
   logic [rlm_pkg::ID_W-1:0] holder;
   int                       depth;
   logic [NTH-1:0]           queued_mask;

   function automatic void give_to_head(output logic ok,
                                        output logic [rlm_pkg::ID_W-1:0] who);
      slot_type s;
      ok = 1'b0;
      who = '0;
      if (ready_fifo.size() != 0) begin
         s = ready_fifo.pop_front();
         held = 1'b1;
         holder = s.id;
         depth = s.count;
         queued_mask[s.id] = 1'b0;
         ok = 1'b1;
         who = s.id;
      end
   endfunction

   function automatic logic shift_waiter();
      if (wait_fifo.size() == 0 || ready_fifo.size() >= NTH) return 1'b0;
      ready_fifo.push_back(wait_fifo.pop_front());
      return 1'b1;
   endfunction

   function automatic lock_result_type predict_lock(logic [rlm_pkg::CMD_W-1:0] cmd,
                                                    logic [rlm_pkg::ID_W-1:0] id);
      lock_result_type          r;
      logic                     mine;
      logic                     inq;
      logic                     hv;
      logic [rlm_pkg::ID_W-1:0] ht;
      slot_type                 s;
      r = '0;
      hv = 1'b0;
      ht = '0;
      mine = held && holder == id;
      inq = queued_mask[id];
      r.status = rlm_pkg::ST_OK;
      case (cmd)
         rlm_pkg::CMD_LOCK, rlm_pkg::CMD_TRY_LOCK: begin
            if (inq) r.status = rlm_pkg::ST_ALREADY_Q;
            else if (!held) begin
               held = 1'b1; holder = id; depth = 1;
            end else if (mine) begin
               if (depth >= rlm_pkg::DEF_MAX_HOLD) r.status = rlm_pkg::ST_SATURATED;
               else depth++;
            end else if (cmd == rlm_pkg::CMD_TRY_LOCK) r.status = rlm_pkg::ST_BUSY;
            else if (ready_fifo.size() < NTH) begin
               s.id = id; s.count = 1;
               ready_fifo.push_back(s);
               queued_mask[id] = 1'b1;
               r.status = rlm_pkg::ST_QUEUED;
            end else r.status = rlm_pkg::ST_BUSY;
         end
         rlm_pkg::CMD_UNLOCK: begin
            if (!mine) r.status = rlm_pkg::ST_NOT_OWNER;
            else begin
               depth--;
               if (depth == 0) begin
                  held = 1'b0; holder = '0;
                  give_to_head(hv, ht);
               end
            end
         end
         rlm_pkg::CMD_WAIT: begin
            if (!mine) r.status = rlm_pkg::ST_NOT_OWNER;
            else if (wait_fifo.size() < NTH) begin
               s.id = id; s.count = depth;
               wait_fifo.push_back(s);
               queued_mask[id] = 1'b1;
               held = 1'b0; holder = '0; depth = 0;
               give_to_head(hv, ht);
               r.status = rlm_pkg::ST_QUEUED;
            end else r.status = rlm_pkg::ST_BUSY;
         end
         rlm_pkg::CMD_NOTIFY: begin
            if (shift_waiter() && !held) give_to_head(hv, ht);
         end
         rlm_pkg::CMD_NOTIFY_ALL: begin
            while (shift_waiter()) begin end
            if (!held) give_to_head(hv, ht);
         end
         default: ;
      endcase
      r.acquired = held && holder == id;
      r.handoff_valid = hv;
      r.handoff_thread = hv ? ht : '0;
      r.owner_valid = held;
      r.owner_thread = held ? holder : '0;
      r.hold_count = held ? depth[rlm_pkg::HOLD_W-1:0] : '0;
      return r;
   endfunction

   always @(posedge clock) begin
      lock_result_type e;
      if (reset) begin
         holder = '0;
         held = 1'b0;
         depth = 0;
         queued_mask = '0;
         ready_fifo.delete();
         wait_fifo.delete();
         result_q.delete();
         fail_count = 0;
         pending_count = 0;
      end else begin
         // check before predicting: the block holds one item at a time
         if (rsp_valid && !rsp_stall) begin
            if (result_q.size() == 0) begin
               $error("result item with nothing expected");
               fail_count++;
            end else begin
               e = result_q.pop_front();
               if (e.status !== rsp_status) begin
                  $error("status exp %0d got %0d", e.status, rsp_status); fail_count++;
               end
               if (e.acquired !== rsp_acquired) begin
                  $error("acquired exp %0d got %0d", e.acquired, rsp_acquired); fail_count++;
               end
               if (e.handoff_valid !== rsp_handoff_valid) begin
                  $error("handoff_valid exp %0d got %0d", e.handoff_valid,
                         rsp_handoff_valid); fail_count++;
               end
               if (e.handoff_thread !== rsp_handoff_thread) begin
                  $error("handoff_thread exp %0d got %0d", e.handoff_thread,
                         rsp_handoff_thread); fail_count++;
               end
               if (e.owner_valid !== rsp_owner_valid) begin
                  $error("owner_valid exp %0d got %0d", e.owner_valid,
                         rsp_owner_valid); fail_count++;
               end
               if (e.owner_thread !== rsp_owner_thread) begin
                  $error("owner_thread exp %0d got %0d", e.owner_thread,
                         rsp_owner_thread); fail_count++;
               end
               if (e.hold_count !== rsp_hold_count) begin
                  $error("hold_count exp %0d got %0d", e.hold_count,
                         rsp_hold_count); fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            result_q.push_back(predict_lock(req_cmd, req_requester_id));
         pending_count = result_q.size();
      end
   end
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [rlm_pkg::CMD_W-1:0]    req_cmd = '0;
   logic [rlm_pkg::ID_W-1:0]     req_requester_id = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [rlm_pkg::STATUS_W-1:0] rsp_status;
   logic                         rsp_acquired;
   logic                         rsp_handoff_valid;
   logic [rlm_pkg::ID_W-1:0]     rsp_handoff_thread;
   logic                         rsp_owner_valid;
   logic [rlm_pkg::ID_W-1:0]     rsp_owner_thread;
   logic [rlm_pkg::HOLD_W-1:0]   rsp_hold_count;
   int                           fail_count;
   int                           pending_count;
   logic                         hold_off_req = 1'b0;

   always #1 clock = ~clock;

   recursive_lock_monitor u_top (.*);

   tb_lock_checker u_chk (.*);

   // present one item and hold it until it is taken; drop valid only for a gap
   task automatic send_item(input logic [rlm_pkg::CMD_W-1:0] c,
                            input logic [rlm_pkg::ID_W-1:0] id,
                            input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_requester_id <= id;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and wait until every expected result has come
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic int pick_gap();
      // mostly back to back, sometimes long gaps
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off_req <= 1'b0;
            @(posedge clock);
         end
         n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int i, k, id;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: saturation on thread 15, queuing, errors, waits, notifies
      send_item(rlm_pkg::CMD_NOTIFY, 4'd0, 0);
      send_item(rlm_pkg::CMD_NOTIFY_ALL, 4'd0, 0);
      send_item(rlm_pkg::CMD_UNLOCK, 4'd3, 0);
      send_item(rlm_pkg::CMD_WAIT, 4'd3, 0);
      send_item(3'd6, 4'd1, 0);
      send_item(3'd7, 4'd14, 0);
      for (i = 0; i < 256; i++) send_item(rlm_pkg::CMD_LOCK, 4'd15, 0);
      send_item(rlm_pkg::CMD_TRY_LOCK, 4'd15, 0);
      send_item(rlm_pkg::CMD_TRY_LOCK, 4'd0, 1);
      send_item(rlm_pkg::CMD_LOCK, 4'd0, 0);
      send_item(rlm_pkg::CMD_LOCK, 4'd0, 0);
      send_item(rlm_pkg::CMD_TRY_LOCK, 4'd0, 0);
      send_item(rlm_pkg::CMD_WAIT, 4'd15, 3);
      send_item(rlm_pkg::CMD_WAIT, 4'd0, 0);
      send_item(rlm_pkg::CMD_LOCK, 4'd15, 0);
      send_item(rlm_pkg::CMD_NOTIFY, 4'd5, 0);
      send_item(rlm_pkg::CMD_NOTIFY_ALL, 4'd5, 0);
      send_item(rlm_pkg::CMD_LOCK, 4'd15, 0);
      send_item(rlm_pkg::CMD_UNLOCK, 4'd0, 0);
      send_item(rlm_pkg::CMD_UNLOCK, 4'd9, 0);

      // lock from every thread to fill the ready queue, then release the lot
      for (k = 0; k < 16; k++) send_item(rlm_pkg::CMD_LOCK, k[3:0], 0);
      for (k = 0; k < 20; k++) send_item(rlm_pkg::CMD_WAIT, u_chk.holder, 0);
      send_item(rlm_pkg::CMD_NOTIFY_ALL, 4'd1, 0);

      // long receiver hold-off while items keep coming
      hold_off_req <= 1'b1;
      for (k = 0; k < 10; k++)
         send_item(3'($urandom_range(0, 5)), 4'($urandom_range(0, 15)), 0);
      // pause until drained
      drain();

      for (i = 0; i < 850; i++) begin
         k = $urandom_range(0, 99);
         id = $urandom_range(0, 15);
         // favor the owner for unlock and wait so sequences go deep
         if (k < 30) send_item(rlm_pkg::CMD_LOCK, (k < 5) ? 4'd2 : id[3:0], pick_gap());
         else if (k < 40) send_item(rlm_pkg::CMD_TRY_LOCK, id[3:0], pick_gap());
         else if (k < 65) send_item(rlm_pkg::CMD_UNLOCK,
                                     ($urandom_range(0, 3) != 0) ? u_chk.holder : id[3:0],
                                     pick_gap());
         else if (k < 78) send_item(rlm_pkg::CMD_WAIT,
                                     ($urandom_range(0, 3) != 0) ? u_chk.holder : id[3:0],
                                     pick_gap());
         else if (k < 88) send_item(rlm_pkg::CMD_NOTIFY, id[3:0], pick_gap());
         else if (k < 95) send_item(rlm_pkg::CMD_NOTIFY_ALL, id[3:0], pick_gap());
         else send_item(3'($urandom_range(0, 7)), id[3:0], pick_gap());
         if (i == 400) drain();
      end

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
